>>> design/trs_pkg.sv
// shared types and constants for the transport segment reassembly block
// no dependencies; imported by the top level
package trs_pkg;

   localparam int DEFAULT_STORE_DEPTH = 2048;

   // longest payload a single segment may announce
   localparam logic [7:0]  MAX_SEGMENT_PAYLOAD = 8'd249;
   localparam logic [11:0] MAX_FRAGMENT_SIZE_RESET = 12'd2048;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 56;

   typedef enum logic [1:0] {
      OP_HEADER = 2'd0,
      OP_BYTE   = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_BYTE_STORED = 4'd0,
      ST_ACCEPTED    = 4'd1,
      ST_COMPLETE    = 4'd2,
      ST_NO_FIR      = 4'd3,
      ST_BAD_SEQ     = 4'd4,
      ST_BAD_ADDR    = 4'd5,
      ST_OVERFLOW    = 4'd6,
      ST_IGNORED     = 4'd7,
      ST_READ        = 4'd8
   } status_type;

   // result while the store read is in flight
   typedef struct packed {
      status_type  status;
      logic        discarded;
      logic [11:0] frag_len;
      logic [15:0] frag_src;
      logic [15:0] frag_dst;
      logic        rd_ok;
   } stage_type;

   // result as presented on the response channel
   typedef struct packed {
      status_type  status;
      logic        discarded;
      logic [11:0] frag_len;
      logic [15:0] frag_src;
      logic [15:0] frag_dst;
      logic [7:0]  read_data;
   } result_type;

endpackage

>>> design/trs_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module trs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // output holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/transport_segment_reassembly_top.sv
// response path: a request's result passes through the stage-one register and the output
//   register before rsp_tvalid rises; a full, unread output register holds stage one back
// throughput: one transaction per cycle unless both result stages are full, set by the single
//   store write port and read port and the read-modify-write of the segment state registers
// reset: synchronous, clears all segment state, max fragment size returns to 2048;
//   fragment store contents are undefined after reset and get no clearing pass
// top level: segment state, fragment store (trs_ram), two-stage response path; uses trs_pkg
module transport_segment_reassembly_top
   import trs_pkg::*;
#(
   parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // config
   input  logic                   csr_wr_en,
   input  logic [11:0]            csr_wr_data,   // max_fragment_size
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // header_byte[7:0], payload_length[15:8], source_address[31:16],
   // destination_address[47:32], data_byte[55:48], read_index[66:56], zero[71:67]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,     // operation[1:0]
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // discarded_previous[0], fragment_length[12:1], fragment_source[28:13],
   // fragment_destination[44:29], read_data[52:45], zero[55:53]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [3:0]             rsp_tuser      // status[3:0]
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int XW = (AW > 12) ? AW : 12;
   localparam logic [16:0] DEPTH_VAL = 17'(STORE_DEPTH);
   localparam logic [12:0] DEPTH_CAP = (STORE_DEPTH > 4096) ? 13'd4096 : 13'(STORE_DEPTH);

   // request fields
   op_type      op;
   logic [7:0]  hdr;
   logic [7:0]  pay_len;
   logic [15:0] src;
   logic [15:0] dst;
   logic [7:0]  data_byte;
   logic [10:0] rd_idx;

   assign op        = op_type'(req_tuser);
   assign hdr       = req_tdata[7:0];
   assign pay_len   = req_tdata[15:8];
   assign src       = req_tdata[31:16];
   assign dst       = req_tdata[47:32];
   assign data_byte = req_tdata[55:48];
   assign rd_idx    = req_tdata[66:56];

   // segment state
   logic [11:0] max_size_ff,  max_size_in;
   logic [11:0] frag_cnt_ff,  frag_cnt_in;
   logic [5:0]  exp_seq_ff,   exp_seq_in;
   logic [15:0] last_src_ff,  last_src_in;
   logic [15:0] last_dst_ff,  last_dst_in;
   logic        seg_open_ff,  seg_open_in;
   logic [7:0]  remain_ff,    remain_in;
   logic [11:0] wr_ptr_ff,    wr_ptr_in;
   logic        pend_fin_ff,  pend_fin_in;

   // response path
   logic        s1_valid_ff,  s1_valid_in;
   stage_type   s1_ff,        s1_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff,       out_in;

   logic        accept;
   logic        s1_move;

   logic        fin, fir;
   logic [5:0]  seq;
   logic [11:0] cnt_base;
   logic [12:0] cnt_sum;
   logic [12:0] eff_size;
   logic [11:0] wr_ptr_inc;
   logic        wr_in_range;
   logic        rd_in_range;

   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [XW-1:0] wr_addr_x;
   logic [XW-1:0] rd_addr_x;
   logic [7:0]    ram_rd_data;

   assign accept     = req_tvalid && req_tready;
   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;

   assign fin      = hdr[7];
   assign fir      = hdr[6];
   assign seq      = hdr[5:0];
   // a first segment starts from an empty fragment
   assign cnt_base = fir ? 12'd0 : frag_cnt_ff;
   assign cnt_sum  = {1'b0, cnt_base} + {5'b0, pay_len};
   assign eff_size = ({1'b0, max_size_ff} > DEPTH_CAP) ? DEPTH_CAP : {1'b0, max_size_ff};

   assign wr_ptr_inc  = wr_ptr_ff + 12'd1;
   assign wr_in_range = {5'b0, wr_ptr_ff} < DEPTH_VAL;
   assign rd_in_range = {6'b0, rd_idx} < DEPTH_VAL;

   assign wr_addr_x = XW'(wr_ptr_ff);
   assign rd_addr_x = XW'(rd_idx);

   assign ram_wr_en = accept && (op == OP_BYTE) && seg_open_ff && wr_in_range;
   assign ram_rd_en = accept && (op == OP_READ) && rd_in_range;

   trs_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_addr_x[AW-1:0]),
      .wr_data (data_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_x[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign max_size_in = csr_wr_en ? csr_wr_data : max_size_ff;

   always_comb begin
      frag_cnt_in = frag_cnt_ff;
      exp_seq_in  = exp_seq_ff;
      last_src_in = last_src_ff;
      last_dst_in = last_dst_ff;
      seg_open_in = seg_open_ff;
      remain_in   = remain_ff;
      wr_ptr_in   = wr_ptr_ff;
      pend_fin_in = pend_fin_ff;
      s1_in       = '{status: ST_IGNORED, discarded: 1'b0, frag_len: 12'd0,
                      frag_src: 16'd0, frag_dst: 16'd0, rd_ok: 1'b0};

      if (accept) begin
         case (op)
            OP_HEADER: begin
               if (pay_len <= MAX_SEGMENT_PAYLOAD) begin
                  // any unfinished segment is abandoned
                  seg_open_in = 1'b0;
                  remain_in   = 8'd0;
                  pend_fin_in = 1'b0;
                  frag_cnt_in = cnt_base;
                  s1_in.discarded = fir && (frag_cnt_ff != 12'd0);
                  if (!fir && (frag_cnt_ff == 12'd0)) begin
                     s1_in.status = ST_NO_FIR;
                  end else if (!fir && (seq != exp_seq_ff)) begin
                     s1_in.status = ST_BAD_SEQ;
                  end else if (!fir && ((src != last_src_ff) || (dst != last_dst_ff))) begin
                     s1_in.status = ST_BAD_ADDR;
                  end else if (cnt_sum > eff_size) begin
                     frag_cnt_in  = 12'd0;
                     s1_in.status = ST_OVERFLOW;
                  end else begin
                     last_src_in  = src;
                     last_dst_in  = dst;
                     exp_seq_in   = seq + 6'd1;
                     s1_in.status = ST_ACCEPTED;
                     if (pay_len == 8'd0) begin
                        if (fin) begin
                           s1_in.status   = ST_COMPLETE;
                           s1_in.frag_len = cnt_base;
                           s1_in.frag_src = src;
                           s1_in.frag_dst = dst;
                           frag_cnt_in    = 12'd0;
                        end
                     end else begin
                        seg_open_in = 1'b1;
                        remain_in   = pay_len;
                        wr_ptr_in   = cnt_base;
                        pend_fin_in = fin;
                     end
                  end
               end
            end
            OP_BYTE: begin
               if (seg_open_ff) begin
                  wr_ptr_in    = wr_ptr_inc;
                  remain_in    = remain_ff - 8'd1;
                  s1_in.status = ST_BYTE_STORED;
                  if (remain_ff == 8'd1) begin
                     seg_open_in = 1'b0;
                     frag_cnt_in = wr_ptr_inc;
                     if (pend_fin_ff) begin
                        pend_fin_in    = 1'b0;
                        frag_cnt_in    = 12'd0;
                        s1_in.status   = ST_COMPLETE;
                        s1_in.frag_len = wr_ptr_inc;
                        s1_in.frag_src = last_src_ff;
                        s1_in.frag_dst = last_dst_ff;
                     end
                  end
               end
            end
            OP_READ: begin
               s1_in.status = ST_READ;
               s1_in.rd_ok  = rd_in_range;
            end
            default: begin
               s1_in.status = ST_IGNORED;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      // store data is still that of the stage-one read when it moves on
      out_in = '{status: s1_ff.status, discarded: s1_ff.discarded,
                 frag_len: s1_ff.frag_len, frag_src: s1_ff.frag_src,
                 frag_dst: s1_ff.frag_dst,
                 read_data: s1_ff.rd_ok ? ram_rd_data : 8'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff  <= MAX_FRAGMENT_SIZE_RESET;
         frag_cnt_ff  <= 12'd0;
         exp_seq_ff   <= 6'd0;
         last_src_ff  <= 16'd0;
         last_dst_ff  <= 16'd0;
         seg_open_ff  <= 1'b0;
         remain_ff    <= 8'd0;
         wr_ptr_ff    <= 12'd0;
         pend_fin_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         max_size_ff  <= max_size_in;
         frag_cnt_ff  <= frag_cnt_in;
         exp_seq_ff   <= exp_seq_in;
         last_src_ff  <= last_src_in;
         last_dst_ff  <= last_dst_in;
         seg_open_ff  <= seg_open_in;
         remain_ff    <= remain_in;
         wr_ptr_ff    <= wr_ptr_in;
         pend_fin_ff  <= pend_fin_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {3'b000, out_ff.read_data, out_ff.frag_dst, out_ff.frag_src,
                        out_ff.frag_len, out_ff.discarded};

   // an open segment always has bytes left to take
   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      seg_open_ff |-> (remain_ff != 8'd0))
      else $error("segment open with no bytes remaining");

   // a completed fragment leaves the byte count cleared
   a_complete_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_ff.status == ST_COMPLETE)) |-> (frag_cnt_ff == 12'd0))
      else $error("fragment count not cleared after completion");

   // input stalls only when both result stages are full
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && out_valid_ff))
      else $error("request stalled with a free result stage");

   // a store read is issued only for read transactions
   a_read_op: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> (s1_valid_ff && (s1_ff.status == ST_READ) && s1_ff.rd_ok))
      else $error("store read without a read result");

endmodule
